[hdl/msp_pkg.sv]
package msp_pkg;

    // Field and register widths
    localparam int unsigned AccW   = 15;
    localparam int unsigned SpeedW = 24;
    localparam int unsigned PosW   = 32;
    localparam int unsigned FracW  = 8;
    localparam int unsigned ProdW  = PosW + AccW;
    localparam int unsigned RootW  = PosW / 2;

    // Input word modes
    localparam logic [2:0] MODE_TICK        = 3'd0;
    localparam logic [2:0] MODE_SET_SPEED   = 3'd1;
    localparam logic [2:0] MODE_OFS_CONSIGN = 3'd2;
    localparam logic [2:0] MODE_OFS_MEAS    = 3'd3;
    localparam logic [2:0] MODE_ABS_POS     = 3'd4;
    localparam logic [2:0] MODE_HARD_STOP   = 3'd5;

    // Configuration register indexes
    localparam logic CFG_ACCEL = 1'b0;
    localparam logic CFG_LIMIT = 1'b1;

    // Rounding constant added before dropping the fraction
    localparam logic [7:0] ROUND_UP = 8'hff;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_DIST,
        S_MUL,
        S_ARG,
        S_SQRT,
        S_RAMP,
        S_ADV,
        S_OUT
    } msp_state_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic ramp_speed;
        logic load_dist;
        logic load_prod;
        logic sqrt_start;
        logic ramp_pos;
        logic advance;
        logic load_out;
    } msp_cmd_t;

    typedef struct packed {
        logic tick_run;
        logic position_mode;
        logic sqrt_done;
        logic out_free;
    } msp_status_t;

endpackage

[hdl/msp_sqrt.sv]
module msp_sqrt
    import msp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [PosW-1:0]  radicand,
    output logic             done,
    output logic [RootW-1:0] root
);

    logic [PosW-1:0] rem_reg, rem_next;
    logic [PosW-1:0] res_reg, res_next;
    logic [PosW-1:0] bit_reg, bit_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [PosW:0]   trial;

    // One result bit per cycle, restoring form
    always_comb
    begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        trial     = {1'b0, res_reg} + {1'b0, bit_reg};
        if (start)
        begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = {2'b01, {(PosW-2){1'b0}}};
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if ({1'b0, rem_reg} >= trial)
            begin
                rem_next = rem_reg - trial[PosW-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[RootW-1:0];

endmodule

[hdl/msp_datapath.sv]
module msp_datapath
    import msp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  msp_cmd_t                 cmd,
    output msp_status_t              status,
    input  logic [2:0]               mode,
    input  logic                     enabled,
    input  logic signed [15:0]       speed_value,
    input  logic signed [PosW-1:0]   position_value,
    input  logic signed [PosW-1:0]   measured_position,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [AccW-1:0]          cfg_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [SpeedW-1:0] speed_out,
    output logic signed [PosW-1:0]   shaft_consign_out,
    output logic                     position_mode_out
);

    // Configuration
    logic [AccW-1:0] accel_reg;
    logic [AccW-1:0] limit_reg;

    // Captured input word
    logic [2:0]      mode_reg;
    logic            enabled_reg;
    logic [15:0]     speed_value_reg;
    logic [PosW-1:0] position_value_reg;
    logic [PosW-1:0] measured_reg;

    // Profile state
    logic [SpeedW-1:0] speed_now_reg, speed_now_next;
    logic [SpeedW-1:0] speed_goal_reg, speed_goal_next;
    logic [PosW-1:0]   position_goal_reg, position_goal_next;
    logic              position_mode_reg, position_mode_next;
    logic [PosW-1:0]   consign_reg, consign_next;

    // Position ramp intermediates
    logic [PosW-1:0]  mag_reg;
    logic             dist_neg_reg;
    logic [ProdW-1:0] prod_reg;

    // Output register
    logic                     out_valid_reg;
    logic [SpeedW-1:0]        speed_out_reg;
    logic [PosW-1:0]          consign_out_reg;
    logic                     pos_mode_out_reg;

    logic             sqrt_done;
    logic [RootW-1:0] sqrt_root;

    logic [PosW-1:0]         delta;
    logic [ProdW+1:0]        arg_sum;
    logic [ProdW-FracW+1:0]  arg_wide;
    logic [PosW-1:0]         sqrt_arg;
    logic signed [SpeedW:0]  gap_up;
    logic signed [SpeedW:0]  acc_25;
    logic [AccW-1:0]         root_cl;
    logic signed [SpeedW+1:0] sf_mag, sf, lo, hi, now_26, acc_26;

    always_comb
    begin
        delta    = position_goal_reg - consign_reg;
        arg_sum  = {1'b0, prod_reg, 1'b0} + {{(ProdW-6){1'b0}}, ROUND_UP};
        arg_wide = arg_sum[ProdW+1:FracW];
        sqrt_arg = (|arg_wide[ProdW-FracW+1:PosW]) ? '1 : arg_wide[PosW-1:0];
    end

    msp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (sqrt_arg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Speed ramp and position ramp arithmetic
    always_comb
    begin
        gap_up  = $signed({speed_goal_reg[SpeedW-1], speed_goal_reg})
                - $signed({speed_now_reg[SpeedW-1], speed_now_reg});
        acc_25  = $signed({{(SpeedW+1-AccW){1'b0}}, accel_reg});
        root_cl = (sqrt_root > {1'b0, limit_reg}) ? limit_reg : sqrt_root[AccW-1:0];
        sf_mag  = $signed({{(SpeedW+2-AccW-FracW){1'b0}}, root_cl, {FracW{1'b0}}});
        sf      = dist_neg_reg ? -sf_mag : sf_mag;
        now_26  = $signed({{2{speed_now_reg[SpeedW-1]}}, speed_now_reg});
        acc_26  = $signed({{(SpeedW+2-AccW){1'b0}}, accel_reg});
        lo      = now_26 - acc_26;
        hi      = now_26 + acc_26;
    end

    always_comb
    begin
        speed_now_next     = speed_now_reg;
        speed_goal_next    = speed_goal_reg;
        position_goal_next = position_goal_reg;
        position_mode_next = position_mode_reg;
        consign_next       = consign_reg;

        if (cmd.apply)
        begin
            unique case (mode_reg)
                MODE_TICK:
                begin
                    speed_now_next = '0;
                end
                MODE_SET_SPEED:
                begin
                    position_mode_next = 1'b0;
                    speed_goal_next    = {speed_value_reg, {FracW{1'b0}}};
                end
                MODE_OFS_CONSIGN:
                begin
                    position_mode_next = 1'b1;
                    position_goal_next = consign_reg + position_value_reg;
                end
                MODE_OFS_MEAS:
                begin
                    position_mode_next = 1'b1;
                    position_goal_next = measured_reg + position_value_reg;
                end
                MODE_ABS_POS:
                begin
                    position_mode_next = 1'b1;
                    position_goal_next = position_value_reg;
                end
                MODE_HARD_STOP:
                begin
                    position_mode_next = 1'b0;
                    speed_now_next     = '0;
                    speed_goal_next    = '0;
                    consign_next       = measured_reg;
                end
                default:
                begin
                    speed_now_next = speed_now_reg;
                end
            endcase
        end

        if (cmd.ramp_speed)
        begin
            if (gap_up > 0)
            begin
                if (gap_up < acc_25)
                    speed_now_next = speed_goal_reg;
                else
                    speed_now_next = speed_now_reg + {{(SpeedW-AccW){1'b0}}, accel_reg};
            end
            else
            begin
                if (-gap_up < acc_25)
                    speed_now_next = speed_goal_reg;
                else
                    speed_now_next = speed_now_reg - {{(SpeedW-AccW){1'b0}}, accel_reg};
            end
        end

        if (cmd.ramp_pos)
        begin
            if (sf < lo)
                speed_now_next = lo[SpeedW-1:0];
            else if (sf > hi)
                speed_now_next = hi[SpeedW-1:0];
            else
                speed_now_next = sf[SpeedW-1:0];
        end

        // Consign moves by the whole-step part, rounded toward minus infinity
        if (cmd.advance)
            consign_next = consign_reg
                         + {{(PosW-SpeedW+FracW){speed_now_reg[SpeedW-1]}},
                            speed_now_reg[SpeedW-1:FracW]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg         <= '0;
            limit_reg         <= '0;
            speed_now_reg     <= '0;
            speed_goal_reg    <= '0;
            position_goal_reg <= '0;
            position_mode_reg <= 1'b0;
            consign_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ACCEL: accel_reg <= cfg_data;
                    CFG_LIMIT: limit_reg <= cfg_data;
                    default:   accel_reg <= accel_reg;
                endcase
            end
            speed_now_reg     <= speed_now_next;
            speed_goal_reg    <= speed_goal_next;
            position_goal_reg <= position_goal_next;
            position_mode_reg <= position_mode_next;
            consign_reg       <= consign_next;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg           <= mode;
            enabled_reg        <= enabled;
            speed_value_reg    <= speed_value;
            position_value_reg <= position_value;
            measured_reg       <= measured_position;
        end
        if (cmd.load_dist)
        begin
            dist_neg_reg <= delta[PosW-1];
            mag_reg      <= delta[PosW-1] ? (~delta + 1'b1) : delta;
        end
        if (cmd.load_prod)
            prod_reg <= mag_reg * accel_reg;
        if (cmd.load_out)
        begin
            speed_out_reg    <= speed_now_reg;
            consign_out_reg  <= consign_reg;
            pos_mode_out_reg <= position_mode_reg;
        end
    end

    always_comb
    begin
        status.tick_run      = (mode_reg == MODE_TICK) && enabled_reg;
        status.position_mode = position_mode_reg;
        status.sqrt_done     = sqrt_done;
        status.out_free      = !out_valid_reg || out_ready;
    end

    assign out_valid         = out_valid_reg;
    assign speed_out         = speed_out_reg;
    assign shaft_consign_out = consign_out_reg;
    assign position_mode_out = pos_mode_out_reg;

endmodule

[hdl/msp_ctrl.sv]
module msp_ctrl
    import msp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  msp_status_t status,
    output msp_cmd_t    cmd
);

    msp_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!status.tick_run)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_OUT;
                end
                else if (status.position_mode)
                begin
                    state_next = S_DIST;
                end
                else
                begin
                    cmd.ramp_speed = 1'b1;
                    state_next     = S_ADV;
                end
            end
            S_DIST:
            begin
                cmd.load_dist = 1'b1;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                cmd.load_prod = 1'b1;
                state_next    = S_ARG;
            end
            S_ARG:
            begin
                cmd.sqrt_start = 1'b1;
                state_next     = S_SQRT;
            end
            S_SQRT:
            begin
                if (status.sqrt_done)
                    state_next = S_RAMP;
            end
            S_RAMP:
            begin
                cmd.ramp_pos = 1'b1;
                state_next   = S_ADV;
            end
            S_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/motion_speed_profile_generator_core.sv]
// Trapezoidal speed profile generator for one motor axis.
// Input channel (in_valid/in_ready): one word per command or control tick;
// mode picks set speed, position target (absolute, from consign, from
// measured position), hard stop, or tick. Output channel (out_valid/
// out_ready): exactly one word per input word, carrying speed (16.8),
// shaft consign and the position-mode flag after that word took effect.
// Config port (cfg_we/cfg_index/cfg_data): 0 acceleration, 1 speed limit;
// write only while the block is idle.
// Sequence: commands are applied and go straight to the output register;
// speed-mode ticks ramp the speed, then advance the consign; position-mode
// ticks pass distance, multiply, argument, the 16-step restoring square
// root (one root bit a cycle) and ramp steps before the advance. One word
// is in work at a time; the next is accepted once the current result sits
// in the output register.
// Stall: a result waits in the output register while out_ready is low;
// the block still accepts and works the next word, then holds it until
// the output register frees.
// Reset: all profile state, configuration and valid flags clear to zero,
// speed mode; no clearing pass.
module motion_speed_profile_generator_core
    import msp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               mode,
    input  logic                     enabled,
    input  logic signed [15:0]       speed_value,
    input  logic signed [PosW-1:0]   position_value,
    input  logic signed [PosW-1:0]   measured_position,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [SpeedW-1:0] speed_out,
    output logic signed [PosW-1:0]   shaft_consign_out,
    output logic                     position_mode_out,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [AccW-1:0]          cfg_data
);

    // Controller to datapath command/status
    msp_cmd_t    cmd;
    msp_status_t status;

    msp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath holds config, profile state, sqrt unit and output register
    msp_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .mode              (mode),
        .enabled           (enabled),
        .speed_value       (speed_value),
        .position_value    (position_value),
        .measured_position (measured_position),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .speed_out         (speed_out),
        .shaft_consign_out (shaft_consign_out),
        .position_mode_out (position_mode_out)
    );

endmodule

[bench/tb_motion_speed_profile_generator_core.sv]
`timescale 1ns / 100ps

// Bench for the speed profile generator core.
// Words are queued by the stimulus process, offered by a clocked driver and
// predicted on acceptance; a clocked monitor pops one prediction per result
// word and compares the three result fields.
module tb_motion_speed_profile_generator_core;
    import msp_pkg::*;

    // Modes with no function; the core must leave its state alone on these
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    localparam int WATCHDOG_LIMIT = 4000; // quiet cycles before giving up
    localparam int SETTLE_CYCLES  = 40;   // settle time after a drain, to outlast a position tick
    localparam int HOLD_OFF_LEN   = 200;  // long receiver stall
    localparam int HOLD_OFF_AT    = 700;  // result count that triggers it
    localparam int CALM_FROM      = 300;  // window with no random idling
    localparam int CALM_TO        = 500;
    localparam int IDLE_PCT       = 8;

    typedef struct {
        logic [2:0]          mode;
        logic                enabled;
        logic signed [15:0]  speed;
        logic signed [31:0]  pos;
        logic signed [31:0]  meas;
    } motion_cmd_t;

    typedef struct {
        logic signed [SpeedW-1:0] speed;
        logic [PosW-1:0]          consign;
        logic                     pmode;
    } motion_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [2:0]               mode = MODE_TICK;
    logic                     enabled = 1'b0;
    logic signed [15:0]       speed_value = '0;
    logic signed [PosW-1:0]   position_value = '0;
    logic signed [PosW-1:0]   measured_position = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [SpeedW-1:0] speed_out;
    logic signed [PosW-1:0]   shaft_consign_out;
    logic                     position_mode_out;
    logic                     cfg_we = 1'b0;
    logic                     cfg_index = CFG_ACCEL;
    logic [AccW-1:0]          cfg_data = '0;

    motion_speed_profile_generator_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mode              (mode),
        .enabled           (enabled),
        .speed_value       (speed_value),
        .position_value    (position_value),
        .measured_position (measured_position),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .speed_out         (speed_out),
        .shaft_consign_out (shaft_consign_out),
        .position_mode_out (position_mode_out),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Profile predictor: own copy of the axis state and the two limits.
    // Everything is zero after reset, speed mode.
    // ------------------------------------------------------------------
    logic [AccW-1:0]          accel = '0;
    logic [AccW-1:0]          limit = '0;
    logic signed [SpeedW-1:0] spd_now = '0;
    logic signed [SpeedW-1:0] spd_goal = '0;
    logic [PosW-1:0]          pos_goal = '0;
    logic                     pos_mode = 1'b0;
    logic [PosW-1:0]          consign = '0;

    motion_cmd_t cmd_q[$];          // words waiting for the driver
    motion_out_t pending_motion[$]; // predicted result words, oldest first

    int words_queued = 0;
    int words_sent = 0;
    int words_seen = 0;
    int mismatches = 0;
    int pos_ticks = 0;
    int phases_run = 0;

    function automatic motion_out_t advance_profile(input motion_cmd_t c);
        motion_out_t r;
        longint cur, tgt, a, mag, arg, root, trial, sf;
        int delta, step, b;
        a = longint'(accel);
        cur = longint'(spd_now);
        case (c.mode)
            MODE_TICK:
                if (c.enabled)
                begin
                    if (pos_mode)
                    begin
                        // Fastest speed that still brakes in time:
                        // floor(sqrt(ceil(2*a*|d| / 256))), argument saturated.
                        pos_ticks++;
                        delta = pos_goal - consign;
                        mag = (delta < 0) ? -longint'(delta) : longint'(delta);
                        arg = (2 * mag * a + longint'(ROUND_UP)) >> FracW;
                        if (arg > 64'hffff_ffff)
                            arg = 64'hffff_ffff;
                        root = 0;
                        for (b = RootW - 1; b >= 0; b--)
                        begin
                            trial = root | (longint'(1) << b);
                            if (trial * trial <= arg)
                                root = trial;
                        end
                        if (root > longint'(limit))
                            root = longint'(limit);
                        sf = root * 256;
                        if (delta < 0)
                            sf = -sf;
                        if (sf < cur - a)
                            sf = cur - a;
                        if (sf > cur + a)
                            sf = cur + a;
                        cur = sf;
                    end
                    else
                    begin
                        // Ramp toward the goal, no overshoot
                        tgt = longint'(spd_goal);
                        if (tgt > cur)
                            cur = (tgt - cur < a) ? tgt : cur + a;
                        else
                            cur = (cur - tgt < a) ? tgt : cur - a;
                    end
                    spd_now = cur[SpeedW-1:0];
                    step = int'(spd_now);
                    step = step >>> FracW;
                    consign = consign + step;
                end
                else
                    spd_now = '0;
            MODE_SET_SPEED:
            begin
                pos_mode = 1'b0;
                spd_goal = {c.speed, {FracW{1'b0}}};
            end
            MODE_OFS_CONSIGN:
            begin
                pos_mode = 1'b1;
                pos_goal = consign + c.pos;
            end
            MODE_OFS_MEAS:
            begin
                pos_mode = 1'b1;
                pos_goal = c.meas + c.pos;
            end
            MODE_ABS_POS:
            begin
                pos_mode = 1'b1;
                pos_goal = c.pos;
            end
            MODE_HARD_STOP:
            begin
                pos_mode = 1'b0;
                spd_now = '0;
                spd_goal = '0;
                consign = c.meas;
            end
            default: ;
        endcase
        r.speed = spd_now;
        r.consign = consign;
        r.pmode = pos_mode;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued words; valid holds with a steady payload until
    // accepted. Prediction happens on the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : driver
        motion_cmd_t c;
        motion_cmd_t cur_cmd;
        logic        taken;
        logic        calm;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            taken = in_valid && in_ready;
            if (taken)
            begin
                cur_cmd.mode = mode;
                cur_cmd.enabled = enabled;
                cur_cmd.speed = speed_value;
                cur_cmd.pos = position_value;
                cur_cmd.meas = measured_position;
                pending_motion.push_back(advance_profile(cur_cmd));
                words_sent++;
            end
            calm = (words_sent >= CALM_FROM) && (words_sent < CALM_TO);
            if (!in_valid || taken)
            begin
                if (cmd_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    c = cmd_q.pop_front();
                    in_valid <= 1'b1;
                    mode <= c.mode;
                    enabled <= c.enabled;
                    speed_value <= c.speed;
                    position_value <= c.pos;
                    measured_position <= c.meas;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each accepted result word against the oldest
    // prediction; drives out_ready with random stalls and one long hold-off
    // so the core fills up and backs off its input.
    // ------------------------------------------------------------------
    int  hold_left = 0;
    bit  held_off = 1'b0;

    always @(posedge clk)
    begin : monitor
        motion_out_t w;
        logic        calm;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                words_seen++;
                if (pending_motion.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: speed %0d consign %0d pmode %0b",
                             $time, speed_out, shaft_consign_out, position_mode_out);
                    mismatches++;
                end
                else
                begin
                    w = pending_motion.pop_front();
                    if (speed_out !== w.speed)
                    begin
                        $display("%0t: speed_out expected %0d got %0d",
                                 $time, w.speed, speed_out);
                        mismatches++;
                    end
                    if (shaft_consign_out !== w.consign)
                    begin
                        $display("%0t: shaft_consign_out expected %h got %h",
                                 $time, w.consign, shaft_consign_out);
                        mismatches++;
                    end
                    if (position_mode_out !== w.pmode)
                    begin
                        $display("%0t: position_mode_out expected %0b got %0b",
                                 $time, w.pmode, position_mode_out);
                        mismatches++;
                    end
                end
            end
            if (!held_off && words_seen >= HOLD_OFF_AT)
            begin
                held_off = 1'b1;
                hold_left = HOLD_OFF_LEN;
            end
            calm = (words_seen >= CALM_FROM) && (words_seen < CALM_TO);
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: cycles with no word moving on either channel
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d results still due",
                     $time, WATCHDOG_LIMIT, pending_motion.size());
            $display("motion_speed_profile_generator_core verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_word(input logic [2:0] m, input logic en, input logic [15:0] sv,
                              input logic [31:0] pv, input logic [31:0] mv);
        motion_cmd_t c;
        c.mode = m;
        c.enabled = en;
        c.speed = sv;
        c.pos = pv;
        c.meas = mv;
        cmd_q.push_back(c);
        words_queued++;
    endtask

    // Wait until every queued word is through and its result checked, then
    // let the core settle before touching the limits.
    task automatic drain();
        while (words_sent != words_queued || pending_motion.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limits(input logic [AccW-1:0] a, input logic [AccW-1:0] l);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_ACCEL;
        cfg_data <= a;
        @(posedge clk);
        cfg_index <= CFG_LIMIT;
        cfg_data <= l;
        @(posedge clk);
        cfg_we <= 1'b0;
        accel = a;
        limit = l;
        phases_run++;
        @(negedge clk);
    endtask

    // Mostly command-then-ticks sequences with random content, plus noise
    task automatic fill_random(input int count);
        int start, r, ticks, k;
        logic [15:0] sv;
        logic [31:0] pv, mv;
        logic [2:0]  m;
        start = words_queued;
        while (words_queued - start < count)
        begin
            r = $urandom_range(0, 99);
            sv = 16'($urandom);
            pv = $urandom;
            mv = $urandom;
            ticks = 0;
            if (r < 30)
            begin
                case ($urandom_range(0, 9))
                    0: sv = 16'h7fff;
                    1: sv = 16'h8000;
                    2, 3, 4, 5: ;
                    default: sv = 16'($urandom_range(0, 400)) - 16'd200;
                endcase
                queue_word(MODE_SET_SPEED, 1'($urandom_range(0, 1)), sv, pv, mv);
                ticks = $urandom_range(3, 30);
            end
            else if (r < 55)
            begin
                // offset targets stay nearby so the profile has room to converge
                case ($urandom_range(0, 2))
                    0:
                    begin
                        m = MODE_OFS_CONSIGN;
                        pv = 32'($urandom_range(0, 8000)) - 32'd4000;
                    end
                    1:
                    begin
                        queue_word(MODE_HARD_STOP, 1'($urandom_range(0, 1)),
                                   16'($urandom), $urandom, mv);
                        m = MODE_OFS_MEAS;
                        pv = 32'($urandom_range(0, 8000)) - 32'd4000;
                    end
                    default: m = MODE_ABS_POS;
                endcase
                queue_word(m, 1'($urandom_range(0, 1)), sv, pv, mv);
                ticks = $urandom_range(5, 40);
            end
            else if (r < 62)
            begin
                queue_word(MODE_HARD_STOP, 1'($urandom_range(0, 1)), sv, pv, mv);
                ticks = $urandom_range(0, 5);
            end
            else if (r < 72)
            begin
                case ($urandom_range(0, 2))
                    0: m = MODE_OFS_CONSIGN;
                    1: m = MODE_OFS_MEAS;
                    default: m = MODE_ABS_POS;
                endcase
                queue_word(m, 1'($urandom_range(0, 1)), sv, pv, mv);
                ticks = $urandom_range(2, 15);
            end
            else
                queue_word(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), sv, pv, mv);
            for (k = 0; k < ticks; k++)
                queue_word(MODE_TICK, $urandom_range(0, 99) < 92, 16'($urandom),
                           $urandom, $urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // Run: reset, directed words, then random phases at several limits
    // ------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: speed extremes, disabled tick, hard stops at the
        // position extremes, each target mode at extreme values, spare modes.
        write_limits(15'd512, 15'd40);
        queue_word(MODE_TICK, 1'b1, 16'h0000, 32'h7fff_ffff, 32'h8000_0000);
        queue_word(MODE_SET_SPEED, 1'b1, 16'h7fff, 32'h0, 32'h0);
        queue_word(MODE_TICK, 1'b1, 16'h0, 32'h0, 32'h0);
        queue_word(MODE_TICK, 1'b1, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
        queue_word(MODE_TICK, 1'b1, 16'h0, 32'h0, 32'h0);
        queue_word(MODE_TICK, 1'b0, 16'h0, 32'h0, 32'h0);
        queue_word(MODE_SET_SPEED, 1'b0, 16'h8000, 32'h0, 32'h0);
        queue_word(MODE_TICK, 1'b1, 16'h0, 32'h0, 32'h0);
        queue_word(MODE_TICK, 1'b1, 16'h0, 32'h0, 32'h0);
        queue_word(MODE_HARD_STOP, 1'b1, 16'h0, 32'h0, 32'h7fff_ffff);
        // consign + 0x80000000 lands at the widest possible distance
        queue_word(MODE_OFS_CONSIGN, 1'b0, 16'h0, 32'h8000_0000, 32'h0);
        queue_word(MODE_TICK, 1'b1, 16'h0, 32'h0, 32'h0);
        queue_word(MODE_TICK, 1'b1, 16'h0, 32'h0, 32'h0);
        queue_word(MODE_OFS_MEAS, 1'b1, 16'h0, 32'h7fff_ffff, 32'h8000_0000);
        queue_word(MODE_TICK, 1'b1, 16'h0, 32'h0, 32'h0);
        queue_word(MODE_ABS_POS, 1'b0, 16'h0, 32'h8000_0000, 32'h0);
        queue_word(MODE_TICK, 1'b1, 16'h0, 32'h0, 32'h0);
        queue_word(MODE_ABS_POS, 1'b1, 16'h0, 32'h0000_0000, 32'h0);
        queue_word(MODE_TICK, 1'b1, 16'h0, 32'h0, 32'h0);
        queue_word(MODE_SPARE_LO, 1'b1, 16'h7fff, 32'h7fff_ffff, 32'h7fff_ffff);
        queue_word(MODE_SPARE_HI, 1'b0, 16'h8000, 32'h8000_0000, 32'h8000_0000);
        queue_word(MODE_HARD_STOP, 1'b0, 16'h0, 32'h0, 32'h8000_0000);
        queue_word(MODE_OFS_CONSIGN, 1'b1, 16'h0, 32'd100, 32'h0);
        queue_word(MODE_TICK, 1'b1, 16'h0, 32'h0, 32'h0);
        queue_word(MODE_TICK, 1'b1, 16'h0, 32'h0, 32'h0);
        drain();

        // Random phases: moderate, both maxima, both zero, minimum step,
        // then a random pair.
        write_limits(15'd256, 15'd100);
        fill_random(210);
        drain();
        write_limits(15'h7fff, 15'h7fff);
        fill_random(210);
        drain();
        write_limits(15'd0, 15'd0);
        fill_random(210);
        drain();
        write_limits(15'd1, 15'd1);
        fill_random(210);
        drain();
        write_limits(15'($urandom_range(2, 4000)), 15'($urandom_range(2, 2000)));
        fill_random(210);
        drain();

        $display("Ran %0d words over %0d limit settings, %0d of them position-mode ticks.",
                 words_sent, phases_run, pos_ticks);
        $display("Checked %0d result words, %0d field mismatches.", words_seen, mismatches);
        if (mismatches == 0)
            $display("motion_speed_profile_generator_core verification clean");
        else
            $display("motion_speed_profile_generator_core verification failed");
        $finish;
    end

endmodule

[motion_speed_profile_generator_core.f]
hdl/msp_pkg.sv
hdl/msp_sqrt.sv
hdl/msp_datapath.sv
hdl/msp_ctrl.sv
hdl/motion_speed_profile_generator_core.sv
bench/tb_motion_speed_profile_generator_core.sv
